/* design/qvr_pkg.sv */
// Package for the quaternion vector rotation unit: field width, default
// fraction width and the packed command and result types.
// Depends on nothing.
package qvr_pkg;

	localparam int QVR_DATA_WIDTH = 16;
	localparam int QVR_FRAC_BITS  = 14;

	typedef struct packed {
		logic signed [QVR_DATA_WIDTH-1:0] quat_w;
		logic signed [QVR_DATA_WIDTH-1:0] quat_x;
		logic signed [QVR_DATA_WIDTH-1:0] quat_y;
		logic signed [QVR_DATA_WIDTH-1:0] quat_z;
		logic signed [QVR_DATA_WIDTH-1:0] vec_x;
		logic signed [QVR_DATA_WIDTH-1:0] vec_y;
		logic signed [QVR_DATA_WIDTH-1:0] vec_z;
	} qvr_cmd_t;

	typedef struct packed {
		logic signed [QVR_DATA_WIDTH-1:0] rot_x;
		logic signed [QVR_DATA_WIDTH-1:0] rot_y;
		logic signed [QVR_DATA_WIDTH-1:0] rot_z;
		logic                             clipped;
	} qvr_result_t;

endpackage

/* design/quaternion_vector_rotate_unit.sv */
// Quaternion vector rotation unit: six-stage pipeline that builds the rotation
// matrix of a quaternion and applies it to a vector.
// Depends on qvr_pkg for the field width and the command and result types.

// The unit takes one command in every clock cycle; busy is always low, so a
// transfer happens at every edge where start is high. Each command yields one
// result, shown for one cycle with done high. The pipeline has six register
// stages: quaternion products, doubled-product rounding, matrix entries with
// clamping, matrix-vector products, row sums with rounding, and output
// saturation. The receiver cannot stall, so results must be taken as they
// appear.
module quaternion_vector_rotate_unit #(
	parameter int FRAC_BITS = qvr_pkg::QVR_FRAC_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  qvr_pkg::qvr_cmd_t    cmd,
	output logic                done,
	output qvr_pkg::qvr_result_t result
);
	import qvr_pkg::*;

	localparam int DW  = QVR_DATA_WIDTH;
	localparam int MW  = ((2 * DW > FRAC_BITS + 6) ? 2 * DW : FRAC_BITS + 6) + 2;
	localparam int CW  = FRAC_BITS + 6;
	localparam int PW  = CW + DW;
	localparam int RW  = PW + 2;

	localparam logic signed [MW-1:0] RND_DP = MW'(1) <<< (FRAC_BITS - 2);
	localparam logic signed [MW-1:0] ONE    = MW'(1) <<< FRAC_BITS;
	localparam logic signed [MW-1:0] LIM    = MW'(1) <<< (FRAC_BITS + 5);
	localparam logic signed [RW-1:0] RND_RS = RW'(1) <<< (FRAC_BITS - 1);
	localparam logic signed [RW-1:0] OMAX   = (RW'(1) <<< (DW - 1)) - RW'(1);
	localparam logic signed [RW-1:0] OMIN   = -(RW'(1) <<< (DW - 1));

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	logic signed [2*DW-1:0] qp_s1  [9];
	logic signed [DW-1:0]   vec_s1 [3];
	logic signed [MW-1:0]   dp_s2  [9];
	logic signed [DW-1:0]   vec_s2 [3];
	logic signed [CW-1:0]   mat_s3 [9];
	logic signed [DW-1:0]   vec_s3 [3];
	logic                   clip_s3;
	logic signed [PW-1:0]   mp_s4  [9];
	logic                   clip_s4;
	logic signed [RW-1:0]   rs_s5  [3];
	logic                   clip_s5;
	qvr_result_t            res_s6;

	logic signed [MW-1:0]   ent    [9];
	logic signed [CW-1:0]   ent_c  [9];
	logic                   ent_clip;
	logic signed [RW-1:0]   row_sum [3];
	logic signed [DW-1:0]   rot_sat [3];
	logic                   out_clip;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		qp_s1[0]  <= cmd.quat_x * cmd.quat_x;
		qp_s1[1]  <= cmd.quat_y * cmd.quat_y;
		qp_s1[2]  <= cmd.quat_z * cmd.quat_z;
		qp_s1[3]  <= cmd.quat_x * cmd.quat_y;
		qp_s1[4]  <= cmd.quat_x * cmd.quat_z;
		qp_s1[5]  <= cmd.quat_y * cmd.quat_z;
		qp_s1[6]  <= cmd.quat_w * cmd.quat_x;
		qp_s1[7]  <= cmd.quat_w * cmd.quat_y;
		qp_s1[8]  <= cmd.quat_w * cmd.quat_z;
		vec_s1[0] <= cmd.vec_x;
		vec_s1[1] <= cmd.vec_y;
		vec_s1[2] <= cmd.vec_z;
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 9; i++) begin
			dp_s2[i] <= ($signed({{(MW-2*DW){qp_s1[i][2*DW-1]}}, qp_s1[i]}) + RND_DP)
				>>> (FRAC_BITS - 1);
		end
		vec_s2 <= vec_s1;
	end

	always_comb begin
		ent[0] = ONE - (dp_s2[1] + dp_s2[2]);
		ent[1] = dp_s2[3] - dp_s2[8];
		ent[2] = dp_s2[4] + dp_s2[7];
		ent[3] = dp_s2[3] + dp_s2[8];
		ent[4] = ONE - (dp_s2[0] + dp_s2[2]);
		ent[5] = dp_s2[5] - dp_s2[6];
		ent[6] = dp_s2[4] - dp_s2[7];
		ent[7] = dp_s2[5] + dp_s2[6];
		ent[8] = ONE - (dp_s2[0] + dp_s2[1]);
		ent_clip = 1'b0;
		for (int i = 0; i < 9; i++) begin
			if (ent[i] < -LIM) begin
				ent_c[i] = CW'(-LIM);
				ent_clip = 1'b1;
			end else if (ent[i] > LIM - MW'(1)) begin
				ent_c[i] = CW'(LIM - MW'(1));
				ent_clip = 1'b1;
			end else begin
				ent_c[i] = ent[i][CW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		mat_s3  <= ent_c;
		vec_s3  <= vec_s2;
		clip_s3 <= ent_clip;
	end

	always_ff @(posedge clk) begin
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				mp_s4[3*r+c] <= mat_s3[3*r+c] * vec_s3[c];
			end
		end
		clip_s4 <= clip_s3;
	end

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			row_sum[r] = ($signed({{2{mp_s4[3*r][PW-1]}}, mp_s4[3*r]})
				+ $signed({{2{mp_s4[3*r+1][PW-1]}}, mp_s4[3*r+1]})
				+ $signed({{2{mp_s4[3*r+2][PW-1]}}, mp_s4[3*r+2]})
				+ RND_RS) >>> FRAC_BITS;
		end
	end

	always_ff @(posedge clk) begin
		rs_s5   <= row_sum;
		clip_s5 <= clip_s4;
	end

	always_comb begin
		out_clip = clip_s5;
		for (int r = 0; r < 3; r++) begin
			if (rs_s5[r] < OMIN) begin
				rot_sat[r] = OMIN[DW-1:0];
				out_clip   = 1'b1;
			end else if (rs_s5[r] > OMAX) begin
				rot_sat[r] = OMAX[DW-1:0];
				out_clip   = 1'b1;
			end else begin
				rot_sat[r] = rs_s5[r][DW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		res_s6.rot_x   <= rot_sat[0];
		res_s6.rot_y   <= rot_sat[1];
		res_s6.rot_z   <= rot_sat[2];
		res_s6.clipped <= out_clip;
	end

	assign done   = v_s6;
	assign result = res_s6;

`ifndef SYNTHESIS
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy went high");

	a_entry_valid: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 == $past(start))
		else $error("transfer not taken into the first stage");

	a_valid_chain: assert property (@(posedge clk) disable iff (!arst_n)
		done == $past(v_s5))
		else $error("valid bit lost between the last two stages");

	a_clip_at_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.clipped && !$past(clip_s5)) |->
		(result.rot_x == OMAX[DW-1:0] || result.rot_x == OMIN[DW-1:0] ||
		 result.rot_y == OMAX[DW-1:0] || result.rot_y == OMIN[DW-1:0] ||
		 result.rot_z == OMAX[DW-1:0] || result.rot_z == OMIN[DW-1:0]))
		else $error("output saturation flagged without a saturated component");
`endif

endmodule
